FILE: rtl/core/modular_exponentiation_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/modexp_pkg.sv
// Shared types for the modular exponentiation block.
// No dependencies; used by modexp_mulmod and the top level.
package modexp_pkg;

    // Status of the bit-serial modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

FILE: rtl/core/modexp_ifs.sv
// Valid/ready channel interfaces for operand and result words.
// No dependencies; used by the top level and its surroundings.
interface modexp_in_if #(
    parameter int unsigned WORD_BITS = 31
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if #(
    parameter int unsigned WORD_BITS = 31
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface

FILE: rtl/core/modexp_mulmod.sv
// Bit-serial modular multiplier: one bit of the multiplier operand per cycle.
// Depends on modexp_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output logic [WORD_BITS-1:0] o_product,
    output t_mm_status           o_status
);

    localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_b;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS:0]   dbl_red;
    logic [WORD_BITS:0]   addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   n_acc;

    // Horner step: acc = (2*acc + b_bit*a) mod m, both adds kept below 2m.
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        addend  = r_b[WORD_BITS-1] ? {1'b0, i_a} : '0;
        sum     = dbl_red + addend;
        n_acc   = (sum >= {1'b0, i_m}) ? sum - {1'b0, i_m} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // Done pulses once, right after the step that uses the last multiplier bit.
            r_done <= r_busy && !i_start && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_acc  <= '0;
                r_b    <= i_b;
                r_cnt  <= CNT_BITS'(WORD_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc[WORD_BITS-1:0];
                r_b   <= {r_b[WORD_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_product     = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `MX_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `MX_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `MX_ASSERT_IMP(a_acc_reduced, i_clk, i_rst_n, (r_busy || r_done) && (i_m != '0), r_acc < i_m)

endmodule

FILE: rtl/core/modular_exponentiation.sv
// Top level: modular exponentiation by square and multiply.
// Depends on modexp_pkg, modexp_ifs, modexp_mulmod and the assertion macros.
//
//   Channel   Dir   Handshake      Contents
//   i_in      in    valid/ready    base, exponent (WORD_BITS each)
//   o_out     out   valid/ready    power_mod (WORD_BITS)
//   cfg       in    write enable   modulus (WORD_BITS), no read-back
//
// One word is worked on at a time. The base is first reduced by one pass of the
// shared bit-serial multiplier, then each exponent bit costs a multiply (set bits
// only) and a square, the top set bit skipping its square; scanning stops once the
// remaining exponent is zero. Reset is synchronous and active low and restores
// the modulus to all ones. A finished result waits in the output register, so a
// new word is taken while the previous result is still stalled downstream.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int unsigned WORD_BITS = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    modexp_in_if.sink            i_in,
    modexp_out_if.source         o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [WORD_BITS-1:0] i_cfg_wr_data
);

    localparam logic [WORD_BITS-1:0] WORD_ONE = WORD_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_NEXT,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [WORD_BITS-1:0] r_modulus;
    logic [WORD_BITS-1:0] r_result;
    logic [WORD_BITS-1:0] r_power;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_mm_a;
    logic [WORD_BITS-1:0] r_mm_b;
    logic                 r_mm_start;
    logic [WORD_BITS-1:0] r_out_data;
    logic                 r_out_valid;

    logic [WORD_BITS-1:0] mm_product;
    t_mm_status           mm_status;
    logic                 exp_rest_zero;
    logic                 n_mm_start;
    logic                 out_load;

    // One shared multiplier serves the base reduction, the multiplies and the
    // squares. Its operands are held in registers for the whole pass.
    modexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mm_start),
        .i_a       (r_mm_a),
        .i_b       (r_mm_b),
        .i_m       (r_modulus),
        .o_product (mm_product),
        .o_status  (mm_status)
    );

    // True when no set exponent bit lies above the current one.
    assign exp_rest_zero = (r_exp[WORD_BITS-1:1] == '0);

    // A pass starts for the base reduction of an accepted word, for every step
    // on a nonzero exponent, and for the square that follows a multiply.
    assign n_mm_start = ((r_state == S_IDLE) && i_in.valid && (r_modulus != '0))
                     || ((r_state == S_NEXT) && (r_exp != '0))
                     || ((r_state == S_MUL) && mm_status.done && !exp_rest_zero);

    // The result moves to the output register once that register is free.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= '1;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= n_mm_start;
            if (i_cfg_wr_en) begin
                r_modulus <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_exp <= i_in.exponent;
                        if (r_modulus == '0) begin
                            // No valid reduction exists; the result is zero.
                            r_result <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            // Start value is 1 mod m; reduce the base as 1 * base.
                            r_result   <= (r_modulus == WORD_ONE) ? '0 : WORD_ONE;
                            r_mm_a     <= WORD_ONE;
                            r_mm_b     <= i_in.base;
                            r_state    <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if (mm_status.done) begin
                        r_power <= mm_product;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_mm_a     <= r_result;
                        r_mm_b     <= r_power;
                        r_state    <= S_MUL;
                    end else begin
                        r_mm_a     <= r_power;
                        r_mm_b     <= r_power;
                        r_state    <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (mm_status.done) begin
                        r_result <= mm_product;
                        if (exp_rest_zero) begin
                            r_state <= S_DONE;
                        end else begin
                            r_mm_a     <= r_power;
                            r_mm_b     <= r_power;
                            r_state    <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (mm_status.done) begin
                        r_power <= mm_product;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_NEXT;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_data  <= r_result;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.power_mod = r_out_data;

    `MX_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, r_mm_start, !mm_status.busy)
    `MX_ASSERT_IMP(a_out_reduced, i_clk, i_rst_n, r_out_valid && (r_modulus != '0), r_out_data < r_modulus)
    `MX_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state != S_IDLE)

endmodule

FILE: test/tb.sv
// Self-checking testbench for the modular exponentiation block.
// Depends on modexp_pkg, the modexp_in_if/modexp_out_if channels and modular_exponentiation.
module tb;

    localparam int unsigned WORD_BITS = 31;
    localparam logic [WORD_BITS-1:0] WORD_MAX = '1;
    // Enough idle time after the end to cover one more full-width word.
    localparam int unsigned DRAIN_CYCLES = 2200;

    // One predicted result, kept with its operands so that a mismatch can be traced.
    typedef struct {
        logic [WORD_BITS-1:0] base;
        logic [WORD_BITS-1:0] exponent;
        logic [WORD_BITS-1:0] power_mod;
    } t_power_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [WORD_BITS-1:0] cfg_wr_data;

    modexp_in_if  #(.WORD_BITS(WORD_BITS)) in_ch ();
    modexp_out_if #(.WORD_BITS(WORD_BITS)) out_ch ();

    modular_exponentiation #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    // Results still owed by the block, oldest first, and our copy of the modulus register.
    t_power_word          pending_powers[$];
    logic [WORD_BITS-1:0] modulus_copy;
    int                   mismatch_count = 0;
    // Percentages of cycles in which the sender and the receiver hold back.
    int                   send_idle_pct = 6;
    int                   recv_idle_pct = 79;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Square and multiply over the whole exponent. The operands stay below 2^31, so a
    // 64-bit product is exact and one remainder gives the modular product directly.
    // A zero modulus has no reduction and yields zero; modulus one yields zero as well.
    function automatic logic [WORD_BITS-1:0] predict_power_mod(
        input logic [WORD_BITS-1:0] base,
        input logic [WORD_BITS-1:0] exponent,
        input logic [WORD_BITS-1:0] modulus
    );
        longint unsigned m;
        longint unsigned acc;
        longint unsigned square;
        int              i;
        if (modulus == '0) begin
            return '0;
        end
        m      = modulus;
        acc    = 1 % m;
        square = base % m;
        for (i = 0; i < WORD_BITS; i++) begin
            if (exponent[i]) begin
                acc = (acc * square) % m;
            end
            square = (square * square) % m;
        end
        return acc[WORD_BITS-1:0];
    endfunction

    // The receiver changes its mind about ready on every falling edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result word taken from the block is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_power_word head;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %0d",
                         $time, out_ch.power_mod);
                mismatch_count++;
            end else begin
                head = pending_powers.pop_front();
                if (out_ch.power_mod !== head.power_mod) begin
                    $display("%0t: power_mod of %0d^%0d mod %0d: expected %0d, actual %0d",
                             $time, head.base, head.exponent, modulus_copy,
                             head.power_mod, out_ch.power_mod);
                    mismatch_count++;
                end
            end
        end
    end

    // Offers one word, with random gaps in front of it, and predicts its result once
    // the block has taken it. Valid stays high after the handshake so that back-to-back
    // words are offered without a gap; the next call or the drain lowers it.
    task automatic send_word(input logic [WORD_BITS-1:0] base,
                             input logic [WORD_BITS-1:0] exponent);
        t_power_word prediction;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.base     = base;
        in_ch.exponent = exponent;
        do @(posedge i_clk); while (!in_ch.ready);
        prediction = '{base, exponent, predict_power_mod(base, exponent, modulus_copy)};
        pending_powers.insert(pending_powers.size(), prediction);
    endtask

    // Every word causes exactly one result, so an empty queue means the block is idle.
    task automatic wait_for_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_powers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_modulus(input logic [WORD_BITS-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge i_clk);
        cfg_wr_en    = 1'b0;
        modulus_copy = value;
    endtask

    // Field extremes and the exponent-zero and exponent-one cases at the reset modulus,
    // which is the all-ones word 2^31 - 1.
    task automatic test_reset_modulus();
        send_word('0, '0);
        send_word(WORD_MAX, '0);
        send_word('0, 1);
        send_word(WORD_MAX, 1);              // base equal to the modulus reduces to zero
        send_word(WORD_MAX - 1, 1);
        send_word(2, 30);
        send_word(2, 31);                    // 2^31 wraps around to one
        send_word(WORD_MAX - 1, WORD_MAX);   // minus one to an odd power
        send_word(3, WORD_MAX);
        send_word(12345, 2);
        send_word('0, WORD_MAX);
        send_word(1, WORD_MAX);
    endtask

    // A zero modulus has no reduction, a modulus of one sends everything to zero,
    // and two is the smallest meaningful modulus.
    task automatic test_degenerate_moduli();
        write_modulus('0);
        send_word(5, 3);
        send_word(WORD_MAX, WORD_MAX);
        send_word('0, '0);
        write_modulus(1);
        send_word(5, 3);
        send_word('0, '0);
        send_word(WORD_MAX, WORD_MAX);
        write_modulus(2);
        send_word('0, '0);
        send_word(3, WORD_MAX);
        send_word(4, 1);
        send_word(WORD_MAX, 5);              // base far above the modulus
    endtask

    // Random words under one modulus. Two in five exponents are short to keep the run brisk;
    // the rest are full width, nearly all ones, or shifted down to a random length.
    task automatic test_random_words(input logic [WORD_BITS-1:0] modulus, input int count);
        logic [WORD_BITS-1:0] base;
        logic [WORD_BITS-1:0] exponent;
        int                   n;
        write_modulus(modulus);
        for (n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0:       base = WORD_BITS'($urandom_range(15));
                1:       base = modulus + WORD_BITS'($urandom_range(3));
                default: base = WORD_BITS'($urandom);
            endcase
            case ($urandom_range(4))
                0:       exponent = WORD_BITS'($urandom);
                1:       exponent = WORD_BITS'($urandom_range(255));
                2:       exponent = WORD_BITS'($urandom) >> $urandom_range(30, 15);
                3:       exponent = WORD_MAX ^ (WORD_BITS'(1) << $urandom_range(WORD_BITS - 1));
                default: exponent = WORD_BITS'($urandom_range(65535));
            endcase
            send_word(base, exponent);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_ch.valid    = 1'b0;
        in_ch.base     = '0;
        in_ch.exponent = '0;
        modulus_copy   = WORD_MAX;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The sender rarely pauses while the receiver mostly stalls.
        send_idle_pct = 6;
        recv_idle_pct = 79;
        test_reset_modulus();
        test_degenerate_moduli();
        test_random_words(WORD_MAX, 50);
        test_random_words(65537, 45);

        // Now the sender mostly pauses while the receiver rarely stalls.
        send_idle_pct = 79;
        recv_idle_pct = 6;
        test_random_words(1000003, 50);
        test_random_words(WORD_BITS'($urandom), 45);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_words(2147483629, 45);
        test_random_words(251, 25);
        test_random_words(WORD_BITS'($urandom), 20);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** modular_exponentiation: PASSED **");
        end else begin
            $display("** modular_exponentiation: FAILED **");
        end
        $finish;
    end

    // A run that hangs is stopped here and reported as failed.
    initial begin
        #30_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
        $display("** modular_exponentiation: FAILED **");
        $finish;
    end

endmodule
